/* hdl/smiru_pkg.sv */
// shared types and constants for the sorted multiset insert/remove unit
// no dependencies; used by the interfaces, the cell and the top level
`timescale 1ns / 1ps

package smiru_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned CmdW         = 2;
  localparam int unsigned KindW        = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_VALUE    = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_ABSENT   = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SHIFT  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic signed [ValueW-1:0] operand;
  } cell_ctrl_t;

endpackage

/* hdl/smiru_if.sv */
// valid/ready channel interfaces for command and result words
// depends on smiru_pkg
`timescale 1ns / 1ps

interface smiru_in_if;
  logic                                valid;
  logic                                ready;
  logic [smiru_pkg::CmdW-1:0]          cmd;
  logic signed [smiru_pkg::ValueW-1:0] operand_value;

  modport source (output valid, output cmd, output operand_value, input ready);
  modport sink (input valid, input cmd, input operand_value, output ready);
endinterface

interface smiru_out_if;
  logic                                valid;
  logic                                ready;
  logic [smiru_pkg::KindW-1:0]         kind;
  logic signed [smiru_pkg::ValueW-1:0] out_value;
  logic                                last;

  modport source (output valid, output kind, output out_value, output last, input ready);
  modport sink (input valid, input kind, input out_value, input last, output ready);
endinterface

/* hdl/smiru_cell.sv */
// one storage cell of the sorted chain: holds a value, compares it to the operand
// depends on smiru_pkg
`timescale 1ns / 1ps

module smiru_cell (
  input  logic                                clk_i,
  input  smiru_pkg::cell_ctrl_t               ctrl_i,
  input  logic                                occupied_i,
  input  logic signed [smiru_pkg::ValueW-1:0] left_value_i,
  input  logic                                left_gt_i,
  input  logic signed [smiru_pkg::ValueW-1:0] right_value_i,
  output logic signed [smiru_pkg::ValueW-1:0] value_o,
  output logic                                gt_o,
  output logic                                eq_o
);

  logic signed [smiru_pkg::ValueW-1:0] value_q, value_d;
  logic                                ge;

  // empty cells count as greater than anything
  assign gt_o    = !(occupied_i && (value_q <= ctrl_i.operand));
  assign ge      = occupied_i && (value_q >= ctrl_i.operand);
  assign eq_o    = occupied_i && (value_q == ctrl_i.operand);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.op)
      smiru_pkg::OP_HOLD:   value_d = value_q;
      // first greater cell takes the operand, the ones after it shift right
      smiru_pkg::OP_INSERT: begin
        if (gt_o) value_d = left_gt_i ? left_value_i : ctrl_i.operand;
      end
      // from the first copy onward everything moves one place left
      smiru_pkg::OP_REMOVE: begin
        if (ge) value_d = right_value_i;
      end
      smiru_pkg::OP_SHIFT:  value_d = right_value_i;
      default:              value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

/* hdl/sorted_multiset_insert_remove_unit.sv */
// top level of the sorted multiset: command decode, result register and cell chain
// depends on smiru_pkg, smiru_if and smiru_cell
`timescale 1ns / 1ps

// Usage
//   in_i carries command words (cmd, operand_value): insert one copy, remove one
//   copy, or finish. out_o carries result words (kind, out_value, last).
//   Values sit in a chain of DEPTH cells kept in ascending order; each cell
//   compares its value with the operand and trades with its neighbors.
//   Insert and remove update the chain as the command is taken; outside a
//   dump, a command is taken whenever the result register is free or being
//   drained in the same cycle. Overflow and remove-of-absent words appear in
//   the cycle after the command. Finish with an empty store gives one empty
//   word in the cycle after; otherwise the chain shifts out one value per cycle
//   from the low end while the result register is free; no command is taken.
//   A remove of an absent value sets a halt flag; inserts and removes are then
//   dropped silently until the next finish, which clears store and flag.
//   While a result word waits with out_o.ready low it holds and in_i.ready
//   drops; the dump simply pauses. Reset empties the store and clears halt
//   and out_o.valid. No clearing pass is needed: occupancy follows the entry count.

module sorted_multiset_insert_remove_unit #(
  parameter int unsigned DEPTH = smiru_pkg::DefaultDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  smiru_in_if.sink         in_i,
  smiru_out_if.source      out_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic        ST_RUN  = 1'b0;
  localparam logic        ST_DUMP = 1'b1;

  // control state
  logic            state_q, state_d;
  logic            halted_q, halted_d;
  logic [CntW-1:0] count_q, count_d;

  // result register
  logic                                out_valid_q, out_valid_d;
  smiru_pkg::kind_e                    kind_q, kind_d;
  logic signed [smiru_pkg::ValueW-1:0] value_q, value_d;
  logic                                last_q, last_d;

  // cell chain
  smiru_pkg::cell_ctrl_t               ctrl;
  logic signed [smiru_pkg::ValueW-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]                    cell_gt;
  logic [DEPTH-1:0]                    cell_eq;
  logic [DEPTH-1:0]                    occupied;

  logic out_free;
  logic accept;
  logic found;
  logic full;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_RUN) && out_free;
  assign accept   = in_i.valid && in_i.ready;
  assign found    = |cell_eq;
  assign full     = (count_q == CntW'(DEPTH));

  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = kind_q;
  assign out_o.out_value = value_q;
  assign out_o.last      = last_q;

  always_comb begin
    state_d     = state_q;
    halted_d    = halted_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_o.ready;
    kind_d      = kind_q;
    value_d     = value_q;
    last_d      = last_q;
    ctrl.op      = smiru_pkg::OP_HOLD;
    ctrl.operand = in_i.operand_value;

    unique case (state_q)
      ST_RUN: begin
        if (accept) begin
          case (smiru_pkg::cmd_e'(in_i.cmd))
            smiru_pkg::CMD_INSERT: begin
              if (!halted_q) begin
                if (full) begin
                  out_valid_d = 1'b1;
                  kind_d      = smiru_pkg::KIND_OVERFLOW;
                  value_d     = '0;
                  last_d      = 1'b1;
                end else begin
                  ctrl.op = smiru_pkg::OP_INSERT;
                  count_d = count_q + CntW'(1);
                end
              end
            end
            smiru_pkg::CMD_REMOVE: begin
              if (!halted_q) begin
                if (!found) begin
                  halted_d    = 1'b1;
                  out_valid_d = 1'b1;
                  kind_d      = smiru_pkg::KIND_ABSENT;
                  value_d     = '0;
                  last_d      = 1'b1;
                end else begin
                  ctrl.op = smiru_pkg::OP_REMOVE;
                  count_d = count_q - CntW'(1);
                end
              end
            end
            smiru_pkg::CMD_FINISH: begin
              halted_d = 1'b0;
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                kind_d      = smiru_pkg::KIND_EMPTY;
                value_d     = '0;
                last_d      = 1'b1;
              end else begin
                state_d = ST_DUMP;
              end
            end
            default: ;  // unused code, no effect
          endcase
        end
      end
      ST_DUMP: begin
        // lowest value leaves from cell 0, the rest move down one place
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = smiru_pkg::KIND_VALUE;
          value_d     = cell_value[0];
          last_d      = (count_q == CntW'(1));
          ctrl.op     = smiru_pkg::OP_SHIFT;
          count_d     = count_q - CntW'(1);
          if (count_q == CntW'(1)) state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      halted_q    <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      halted_q    <= halted_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    value_q <= value_d;
    last_q  <= last_d;
  end

  // chain of cells; cell i is occupied when i is below the entry count
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [smiru_pkg::ValueW-1:0] left_value;
    logic                                left_gt;
    logic signed [smiru_pkg::ValueW-1:0] right_value;

    assign occupied[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_value = ctrl.operand;
      assign left_gt    = 1'b0;
    end else begin : g_inner
      assign left_value = cell_value[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_value = cell_value[i];
    end else begin : g_mid
      assign right_value = cell_value[i+1];
    end

    smiru_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (occupied[i]),
      .left_value_i (left_value),
      .left_gt_i    (left_gt),
      .right_value_i(right_value),
      .value_o      (cell_value[i]),
      .gt_o         (cell_gt[i]),
      .eq_o         (cell_eq[i])
    );
  end

endmodule

/* dv/sorted_multiset_insert_remove_unit_test.sv */
// testbench for the sorted multiset insert/remove unit: directed and random command words
// checked against a queue-based multiset predictor; depends on smiru_pkg, smiru_if and the rtl
`timescale 1ns / 1ps

module sorted_multiset_insert_remove_unit_test;
  import smiru_pkg::*;

  localparam int unsigned Depth = DefaultDepth;
  localparam int unsigned RandomWords = 200;
  localparam int unsigned SteadyWords = 40;
  // code 3 on the command field is not a command; the unit must ignore it
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam logic signed [ValueW-1:0] MinValue = {1'b1, {(ValueW-1){1'b0}}};
  localparam logic signed [ValueW-1:0] MaxValue = {1'b0, {(ValueW-1){1'b1}}};
  localparam logic signed [ValueW-1:0] MinusOne = '1;

  typedef struct {
    kind_e                    kind;
    logic signed [ValueW-1:0] value;
    logic                     last;
  } result_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  smiru_in_if  in_ch ();
  smiru_out_if out_ch ();

  sorted_multiset_insert_remove_unit #(
    .DEPTH(Depth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #4 clk_i = ~clk_i;

  // predictor state: the multiset in ascending order and the halt flag
  logic signed [ValueW-1:0] stored_values[$];
  bit                       store_halted;
  result_word_t             pending_results[$];

  int unsigned failures;
  int unsigned useful_words;  // accepted words that were not ignored
  bit          bursts_on;     // random idling on both channels
  int          sink_gap;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void expect_word(kind_e kind, logic signed [ValueW-1:0] value,
                                      logic last);
    result_word_t w;
    w.kind  = kind;
    w.value = value;
    w.last  = last;
    pending_results.push_back(w);
  endfunction

  // applies one accepted command word to the multiset and queues the words it causes
  function automatic void predict_results(logic [CmdW-1:0] cmd,
                                          logic signed [ValueW-1:0] operand);
    int pos;
    case (cmd)
      CMD_INSERT: begin
        if (!store_halted) begin
          useful_words++;
          if (stored_values.size() >= Depth) begin
            // full store: the value is dropped, halt stays as it was
            expect_word(KIND_OVERFLOW, '0, 1'b1);
          end else begin
            // after any equal copies, so duplicates keep arrival order
            pos = 0;
            while (pos < stored_values.size() && stored_values[pos] <= operand) pos++;
            stored_values.insert(pos, operand);
          end
        end
      end
      CMD_REMOVE: begin
        if (!store_halted) begin
          useful_words++;
          pos = 0;
          while (pos < stored_values.size() && stored_values[pos] != operand) pos++;
          if (pos == stored_values.size()) begin
            store_halted = 1'b1;
            expect_word(KIND_ABSENT, '0, 1'b1);
          end else begin
            stored_values.delete(pos);
          end
        end
      end
      CMD_FINISH: begin
        useful_words++;
        if (stored_values.size() == 0) begin
          expect_word(KIND_EMPTY, '0, 1'b1);
        end else begin
          foreach (stored_values[i])
            expect_word(KIND_VALUE, stored_values[i], i == stored_values.size() - 1);
        end
        stored_values.delete();
        store_halted = 1'b0;
      end
      default: begin
        // unused code, nothing happens
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mix of a narrow range (duplicates, hits on remove), extremes and full-range values
  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1, 2: pick_value = $signed($urandom_range(0, 15)) - 8;
      3: begin
        case ($urandom_range(0, 3))
          0: pick_value = MinValue;
          1: pick_value = MaxValue;
          2: pick_value = MinusOne;
          default: pick_value = '0;
        endcase
      end
      default: pick_value = $urandom;
    endcase
  endfunction

  function automatic logic signed [ValueW-1:0] absent_value();
    logic signed [ValueW-1:0] v;
    int hits[$];
    do begin
      v = $urandom;
      hits = stored_values.find_index(e) with (e == v);
    end while (hits.size() != 0);
    return v;
  endfunction

  function automatic logic signed [ValueW-1:0] present_value();
    return stored_values[$urandom_range(0, stored_values.size() - 1)];
  endfunction

  // sends one command word; returns at the edge where it is accepted
  task automatic send_word(logic [CmdW-1:0] cmd, logic signed [ValueW-1:0] operand);
    int gap;
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      in_ch.valid         <= 1'b0;
      in_ch.cmd           <= CmdW'($urandom);
      in_ch.operand_value <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= cmd;
    in_ch.operand_value <= operand;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_results(cmd, operand);
  endtask

  // sender holds off until every queued result word has been taken
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // one batch: inserts and removes of present values, optional noise words (unused code, absent remove), then a finish
  task automatic send_batch(int unsigned length, bit with_noise);
    repeat (length) begin
      if (with_noise && $urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 0) send_word(CmdUnused, $urandom);
        else send_word(CMD_REMOVE, absent_value());
      end else if (stored_values.size() != 0 && $urandom_range(0, 9) < 4) begin
        send_word(CMD_REMOVE, present_value());
      end else begin
        send_word(CMD_INSERT, pick_value());
      end
    end
    send_word(CMD_FINISH, $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // ordering, extremes, duplicates, -1 as a normal value, unused code, empty finish
  task automatic test_ordering();
    send_word(CMD_FINISH, '0);
    send_word(CMD_INSERT, MaxValue);
    send_word(CMD_INSERT, MinValue);
    send_word(CMD_INSERT, MinusOne);
    send_word(CMD_INSERT, '0);
    send_word(CMD_INSERT, 32'sd5);
    send_word(CMD_INSERT, 32'sd5);
    send_word(CMD_INSERT, MinusOne);
    send_word(CMD_REMOVE, 32'sd5);
    send_word(CMD_REMOVE, MinusOne);
    send_word(CmdUnused, MaxValue);
    send_word(CMD_FINISH, MinusOne);
    send_word(CMD_FINISH, MaxValue);
  endtask

  // remove of an absent value halts inserts and removes until the next finish
  task automatic test_absent_halt();
    send_word(CMD_INSERT, 32'sd7);
    send_word(CMD_INSERT, 32'sd3);
    send_word(CMD_REMOVE, 32'sd9);
    send_word(CMD_INSERT, 32'sd1);
    send_word(CMD_REMOVE, 32'sd7);
    send_word(CMD_REMOVE, 32'sd9);
    send_word(CMD_FINISH, '0);
    send_word(CMD_REMOVE, '0);
    send_word(CMD_FINISH, '0);
    send_word(CMD_INSERT, 32'sd4);
    send_word(CMD_FINISH, '0);
  endtask

  // fill to capacity, overflow, halt on a full store, then a full dump
  task automatic test_full_store();
    repeat (Depth) send_word(CMD_INSERT, pick_value());
    send_word(CMD_INSERT, MaxValue);
    send_word(CMD_REMOVE, present_value());
    send_word(CMD_INSERT, MinValue);
    send_word(CMD_INSERT, pick_value());
    wait_for_drain();
    send_word(CMD_REMOVE, absent_value());
    send_word(CMD_INSERT, pick_value());
    wait_for_drain();
    send_word(CMD_FINISH, '0);
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    int unsigned n;
    stop_at = useful_words + RandomWords;
    while (useful_words < stop_at) begin
      case ($urandom_range(0, 19))
        0: begin
          // broken sequence: any code, any value
          repeat ($urandom_range(1, 6)) send_word(CmdW'($urandom), $urandom);
        end
        1: send_batch($urandom_range(Depth, Depth + 6), 1'b0);
        2: begin
          wait_for_drain();
          send_batch($urandom_range(1, 12), 1'b1);
        end
        default: begin
          n = $urandom_range(0, 3) == 0 ? $urandom_range(13, 30) : $urandom_range(1, 12);
          send_batch(n, 1'b1);
        end
      endcase
    end
  endtask

  task automatic test_steady_stream();
    int unsigned stop_at;
    bursts_on = 1'b0;
    stop_at = useful_words + SteadyWords;
    while (useful_words < stop_at) send_batch($urandom_range(1, 10), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls and comparison with the oldest expected word
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (sink_gap > 0) sink_gap--;
    else if (bursts_on && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 11);
    out_ch.ready <= (sink_gap == 0);
  end

  always @(posedge clk_i) begin
    result_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with none expected: kind %0d, out_value %0d, last %0d",
               out_ch.kind, out_ch.out_value, out_ch.last);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_ch.kind);
          failures++;
        end
        if (out_ch.out_value !== want.value) begin
          $error("out_value: expected %0d, actual %0d", want.value, out_ch.out_value);
          failures++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_ch.last);
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = CMD_INSERT;
    in_ch.operand_value = '0;
    out_ch.ready        = 1'b0;
    sink_gap            = 0;
    failures            = 0;
    useful_words        = 0;
    store_halted        = 1'b0;
    bursts_on           = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ordering();
    test_absent_halt();
    test_full_store();
    test_random_traffic();
    test_steady_stream();

    // let any stray word past the last expected one show up
    wait_for_drain();
    repeat (Depth + 20) @(posedge clk_i);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* sorted_multiset_insert_remove_unit.f */
hdl/smiru_pkg.sv
hdl/smiru_if.sv
hdl/smiru_cell.sv
hdl/sorted_multiset_insert_remove_unit.sv
dv/sorted_multiset_insert_remove_unit_test.sv
